@@ rtl/core/shc_pkg.sv @@
// Shared constants and types of the set-associative handle cache.
`default_nettype none

package shc_pkg;

  // Default geometry
  localparam int unsigned SETS_DEF        = 64;
  localparam int unsigned WAYS_DEF        = 4;
  localparam int unsigned KEY_BITS_DEF    = 32;
  localparam int unsigned HANDLE_BITS_DEF = 32;

  // Fixed port widths
  localparam int unsigned SET_IDX_W = 6;
  localparam int unsigned KEY_W     = 32;
  localparam int unsigned HANDLE_W  = 32;
  localparam int unsigned COUNT_W   = 32;

  // Way index field wide enough for the largest way count (16)
  localparam int unsigned WAY_IDX_W = 4;

  // Tag compare result
  typedef struct packed {
    logic                 hit;
    logic [WAY_IDX_W-1:0] way;
  } lookup_t;

endpackage

`default_nettype wire

@@ rtl/core/shc_ram.sv @@
// Single-port-write, single-port-read synchronous RAM with registered read data.
`default_nettype none

module shc_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 8,
  parameter int unsigned AW    = 6
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output      logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ rtl/core/shc_match.sv @@
// Parallel tag compare over the ways of one set, lowest matching way wins.
`default_nettype none

module shc_match #(
  parameter int unsigned WAYS     = 4,
  parameter int unsigned KEY_BITS = 32
) (
  input  wire logic [WAYS-1:0]          valid_i,
  input  wire logic [WAYS*KEY_BITS-1:0] keys_i,
  input  wire logic [KEY_BITS-1:0]      key_i,
  output      shc_pkg::lookup_t         lookup_o
);

  always_comb begin
    lookup_o = '0;
    // walk downward so the lowest match is the last one written
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (valid_i[w] && (keys_i[w*KEY_BITS +: KEY_BITS] == key_i)) begin
        lookup_o.hit = 1'b1;
        lookup_o.way = shc_pkg::WAY_IDX_W'(w);
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/set_assoc_handle_cache.sv @@
// Top level of the set-associative handle cache with round-robin replacement.
`default_nettype none

// Set-associative handle cache. Each word on the input channel names a set,
// a key and a freshly built handle with its build flag; one result word comes
// back per request. The key is compared against all valid ways of the set in
// parallel. A hit returns the stored handle. A miss with build_ok set writes
// key and handle into the set's round-robin way and advances that pointer;
// if the way was occupied, the displaced key and handle are reported and the
// collision count goes up. A miss without build_ok stores nothing.
// A request first reads its set's row from the tag and data RAMs (registered
// read data); once the output side is free it is then compared, written back
// and loaded into the output register, and only then is a new word taken. The
// output register lets a new request be accepted while the previous result
// still waits. After reset the block runs a clearing pass over the tag RAM
// (valid bits and pointers) and holds in_stall_o high for that time. Set
// indexes at or above SETS are reduced modulo SETS. The three totals wrap at
// 32 bits.

module set_assoc_handle_cache #(
  parameter int unsigned SETS        = shc_pkg::SETS_DEF,
  parameter int unsigned WAYS        = shc_pkg::WAYS_DEF,
  parameter int unsigned KEY_BITS    = shc_pkg::KEY_BITS_DEF,
  parameter int unsigned HANDLE_BITS = shc_pkg::HANDLE_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // request channel
  input  wire logic                          in_valid_i,
  output      logic                          in_stall_o,
  input  wire logic [shc_pkg::SET_IDX_W-1:0] set_index_i,
  input  wire logic [shc_pkg::KEY_W-1:0]     key_i,
  input  wire logic                          build_ok_i,
  input  wire logic [shc_pkg::HANDLE_W-1:0]  new_handle_i,
  // result channel
  output      logic                          out_valid_o,
  input  wire logic                          out_stall_i,
  output      logic                          hit_o,
  output      logic                          handle_valid_o,
  output      logic [shc_pkg::HANDLE_W-1:0]  result_handle_o,
  output      logic                          evicted_o,
  output      logic [shc_pkg::KEY_W-1:0]     evicted_key_o,
  output      logic [shc_pkg::HANDLE_W-1:0]  evicted_handle_o,
  output      logic [shc_pkg::COUNT_W-1:0]   request_total_o,
  output      logic [shc_pkg::COUNT_W-1:0]   hit_total_o,
  output      logic [shc_pkg::COUNT_W-1:0]   collision_total_o
);

  localparam int unsigned SET_AW   = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int unsigned WAY_AW   = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned TAG_W    = WAY_AW + WAYS;           // {ptr, valid[WAYS]}
  localparam int unsigned ENT_W    = KEY_BITS + HANDLE_BITS;  // {handle, key}
  localparam int unsigned ROW_W    = WAYS * ENT_W;
  localparam int unsigned IDX_N    = 2 ** shc_pkg::SET_IDX_W;
  localparam int unsigned CNT_W    = shc_pkg::COUNT_W;

  // controller states
  localparam logic [1:0] ST_CLEAR = 2'd0;  // tag RAM clearing pass
  localparam logic [1:0] ST_IDLE  = 2'd1;  // ready for a request
  localparam logic [1:0] ST_LOOK  = 2'd2;  // row data back, compare and update

  logic [1:0] state_q, state_d;
  logic [SET_AW-1:0] clr_q, clr_d;

  // set index reduction, constant table
  logic [SET_AW-1:0] set_tbl [IDX_N];
  for (genvar i = 0; i < IDX_N; i++) begin : g_set_tbl
    assign set_tbl[i] = SET_AW'(i % SETS);
  end

  // latched request
  logic [SET_AW-1:0]      set_q;
  logic [KEY_BITS-1:0]    req_key_q;
  logic                   req_ok_q;
  logic [HANDLE_BITS-1:0] req_hdl_q;

  logic accept;
  logic fire;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign fire       = (state_q == ST_LOOK) && (!out_valid_o || !out_stall_i);

  always_ff @(posedge clk_i) begin
    if (accept) begin
      set_q     <= set_tbl[set_index_i];
      req_key_q <= KEY_BITS'(key_i);
      req_ok_q  <= build_ok_i;
      req_hdl_q <= HANDLE_BITS'(new_handle_i);
    end
  end

  // ---------------------------------------------------------------------------
  // Memories: tag row {ptr, valid} and data row {handle, key} per way
  // ---------------------------------------------------------------------------
  logic              tag_we;
  logic [SET_AW-1:0] tag_waddr;
  logic [TAG_W-1:0]  tag_wdata, tag_rdata;
  logic              data_we;
  logic [ROW_W-1:0]  data_wdata, data_rdata;

  shc_ram #(
    .DEPTH (SETS),
    .WIDTH (TAG_W),
    .AW    (SET_AW)
  ) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (tag_we),
    .waddr_i (tag_waddr),
    .wdata_i (tag_wdata),
    .re_i    (accept),
    .raddr_i (set_tbl[set_index_i]),
    .rdata_o (tag_rdata)
  );

  shc_ram #(
    .DEPTH (SETS),
    .WIDTH (ROW_W),
    .AW    (SET_AW)
  ) u_data_ram (
    .clk_i   (clk_i),
    .we_i    (data_we),
    .waddr_i (set_q),
    .wdata_i (data_wdata),
    .re_i    (accept),
    .raddr_i (set_tbl[set_index_i]),
    .rdata_o (data_rdata)
  );

  // ---------------------------------------------------------------------------
  // Compare and replacement
  // ---------------------------------------------------------------------------
  logic [WAYS-1:0]          row_valid;
  logic [WAY_AW-1:0]        victim;
  logic [WAYS*KEY_BITS-1:0] row_keys;
  logic [KEY_BITS-1:0]      way_key    [WAYS];
  logic [HANDLE_BITS-1:0]   way_handle [WAYS];
  shc_pkg::lookup_t         lookup;

  assign row_valid = tag_rdata[WAYS-1:0];
  assign victim    = tag_rdata[TAG_W-1 -: WAY_AW];

  for (genvar w = 0; w < WAYS; w++) begin : g_unpack
    assign way_key[w]                      = data_rdata[w*ENT_W +: KEY_BITS];
    assign way_handle[w]                   = data_rdata[w*ENT_W + KEY_BITS +: HANDLE_BITS];
    assign row_keys[w*KEY_BITS +: KEY_BITS] = way_key[w];
  end

  shc_match #(
    .WAYS     (WAYS),
    .KEY_BITS (KEY_BITS)
  ) u_match (
    .valid_i  (row_valid),
    .keys_i   (row_keys),
    .key_i    (req_key_q),
    .lookup_o (lookup)
  );

  logic              do_fill;     // miss with a good build: write the victim way
  logic              do_evict;    // victim way held a live entry
  logic [WAY_AW-1:0] victim_next;

  assign do_fill     = !lookup.hit && req_ok_q;
  assign do_evict    = do_fill && row_valid[victim];
  assign victim_next = (victim == WAY_AW'(WAYS - 1)) ? '0 : victim + 1'b1;

  always_comb begin
    data_wdata = data_rdata;
    for (int w = 0; w < WAYS; w++) begin
      if (WAY_AW'(w) == victim) begin
        data_wdata[w*ENT_W +: ENT_W] = {req_hdl_q, req_key_q};
      end
    end
  end

  assign data_we = fire && do_fill;

  // tag writes come from the clearing pass or from a fill
  always_comb begin
    tag_we    = 1'b0;
    tag_waddr = set_q;
    tag_wdata = {victim_next, row_valid | (WAYS'(1) << victim)};
    if (state_q == ST_CLEAR) begin
      tag_we    = 1'b1;
      tag_waddr = clr_q;
      tag_wdata = '0;
    end else if (fire && do_fill) begin
      tag_we    = 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Controller
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == SET_AW'(SETS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (fire) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
        clr_d   = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Totals and output register
  // ---------------------------------------------------------------------------
  logic [CNT_W-1:0] req_cnt_q, hit_cnt_q, col_cnt_q;
  logic             out_valid_q;

  // counters only move on fire, which needs the output word free or leaving,
  // so they always match the word on the output
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_cnt_q   <= '0;
      hit_cnt_q   <= '0;
      col_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        req_cnt_q   <= req_cnt_q + 1'b1;
        hit_cnt_q   <= hit_cnt_q + CNT_W'(lookup.hit);
        col_cnt_q   <= col_cnt_q + CNT_W'(do_evict);
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  logic                         hit_q, hv_q, ev_q;
  logic [shc_pkg::HANDLE_W-1:0] rh_q, eh_q;
  logic [shc_pkg::KEY_W-1:0]    ek_q;

  always_ff @(posedge clk_i) begin
    if (fire) begin
      hit_q <= lookup.hit;
      hv_q  <= lookup.hit || req_ok_q;
      if (lookup.hit) begin
        rh_q <= shc_pkg::HANDLE_W'(way_handle[lookup.way[WAY_AW-1:0]]);
      end else if (req_ok_q) begin
        rh_q <= shc_pkg::HANDLE_W'(req_hdl_q);
      end else begin
        rh_q <= '0;
      end
      ev_q <= do_evict;
      if (do_evict) begin
        ek_q <= shc_pkg::KEY_W'(way_key[victim]);
        eh_q <= shc_pkg::HANDLE_W'(way_handle[victim]);
      end else begin
        ek_q <= '0;
        eh_q <= '0;
      end
    end
  end

  assign out_valid_o       = out_valid_q;
  assign hit_o             = hit_q;
  assign handle_valid_o    = hv_q;
  assign result_handle_o   = rh_q;
  assign evicted_o         = ev_q;
  assign evicted_key_o     = ek_q;
  assign evicted_handle_o  = eh_q;
  assign request_total_o   = req_cnt_q;
  assign hit_total_o       = hit_cnt_q;
  assign collision_total_o = col_cnt_q;

endmodule

`default_nettype wire

@@ tb/sv/tb_set_assoc_handle_cache.sv @@
// Self-checking testbench for the set-associative handle cache.
`timescale 1ns / 100ps

module tb_set_assoc_handle_cache;
  import shc_pkg::*;

  localparam int unsigned SETS = SETS_DEF;
  localparam int unsigned WAYS = WAYS_DEF;

  // Receiver hold-off length; long enough that the block fills and stalls.
  localparam int unsigned RX_HOLD_CYCLES = 150;
  // Cycles allowed for the pipeline to settle once nothing is pending.
  localparam int unsigned TAIL_CYCLES    = 8;
  // Upper bound on any single drain wait.
  localparam int unsigned DRAIN_LIMIT    = 5000;

  // One result word as the block reports it.
  typedef struct packed {
    logic                hit;
    logic                handle_valid;
    logic [HANDLE_W-1:0] result_handle;
    logic                evicted;
    logic [KEY_W-1:0]    evicted_key;
    logic [HANDLE_W-1:0] evicted_handle;
    logic [COUNT_W-1:0]  request_total;
    logic [COUNT_W-1:0]  hit_total;
    logic [COUNT_W-1:0]  collision_total;
  } lookup_result_t;

  // DUT interface; every input is known from time zero.
  logic                 clk_i        = 1'b0;
  logic                 rst_ni       = 1'b0;
  logic                 in_valid_i   = 1'b0;
  logic                 in_stall_o;
  logic [SET_IDX_W-1:0] set_index_i  = '0;
  logic [KEY_W-1:0]     key_i        = '0;
  logic                 build_ok_i   = 1'b0;
  logic [HANDLE_W-1:0]  new_handle_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i  = 1'b0;
  logic                 hit_o;
  logic                 handle_valid_o;
  logic [HANDLE_W-1:0]  result_handle_o;
  logic                 evicted_o;
  logic [KEY_W-1:0]     evicted_key_o;
  logic [HANDLE_W-1:0]  evicted_handle_o;
  logic [COUNT_W-1:0]   request_total_o;
  logic [COUNT_W-1:0]   hit_total_o;
  logic [COUNT_W-1:0]   collision_total_o;

  set_assoc_handle_cache i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .set_index_i      (set_index_i),
    .key_i            (key_i),
    .build_ok_i       (build_ok_i),
    .new_handle_i     (new_handle_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .hit_o            (hit_o),
    .handle_valid_o   (handle_valid_o),
    .result_handle_o  (result_handle_o),
    .evicted_o        (evicted_o),
    .evicted_key_o    (evicted_key_o),
    .evicted_handle_o (evicted_handle_o),
    .request_total_o  (request_total_o),
    .hit_total_o      (hit_total_o),
    .collision_total_o(collision_total_o)
  );

  // ---------------------------------------------------------------------------
  // Shadow copy of the cache contents. Tags and handles are only looked at
  // behind a set valid bit, so their initial contents never matter.
  // ---------------------------------------------------------------------------
  bit                  line_valid  [SETS*WAYS];
  logic [KEY_W-1:0]    line_key    [SETS*WAYS];
  logic [HANDLE_W-1:0] line_handle [SETS*WAYS];
  int unsigned         victim_way  [SETS];
  logic [COUNT_W-1:0]  requests_seen   = '0;
  logic [COUNT_W-1:0]  hits_seen       = '0;
  logic [COUNT_W-1:0]  collisions_seen = '0;

  // Results owed by the block, oldest first.
  lookup_result_t lookup_results_q[$];
  int unsigned    mismatches = 0;

  // Pacing knobs shared by the test tasks, send_word and the result pacing process.
  bit tx_quiet    = 1'b0;  // sender never idles
  bit rx_quiet    = 1'b0;  // receiver never stalls
  bit rx_hold_req = 1'b0;  // ask the receiver for one long hold-off

  // Keys reused by the random traffic so hits and evictions are common.
  logic [KEY_W-1:0]     key_pool [8];
  logic [SET_IDX_W-1:0] hot_sets [4];

  // Look up one request in the shadow cache and apply its side effects:
  // hit returns the stored handle; a built miss fills the round-robin way,
  // reporting whatever valid line it displaced; a failed miss stores nothing.
  function automatic lookup_result_t predict_lookup(input logic [SET_IDX_W-1:0] set_idx,
                                                    input logic [KEY_W-1:0]     key,
                                                    input logic                 ok,
                                                    input logic [HANDLE_W-1:0]  handle);
    lookup_result_t r;
    int unsigned    base;
    int unsigned    slot;
    bit             found;
    r     = '0;
    found = 1'b0;
    base  = (int'(set_idx) % SETS) * WAYS;
    requests_seen++;
    // Lowest matching way answers.
    for (int w = 0; w < WAYS; w++) begin
      if (!found && line_valid[base+w] && line_key[base+w] == key) begin
        found           = 1'b1;
        r.hit           = 1'b1;
        r.handle_valid  = 1'b1;
        r.result_handle = line_handle[base+w];
      end
    end
    if (found) begin
      hits_seen++;
    end else if (ok) begin
      slot = base + victim_way[int'(set_idx) % SETS];
      if (line_valid[slot]) begin
        r.evicted        = 1'b1;
        r.evicted_key    = line_key[slot];
        r.evicted_handle = line_handle[slot];
        collisions_seen++;
      end
      line_valid[slot]  = 1'b1;
      line_key[slot]    = key;
      line_handle[slot] = handle;
      victim_way[int'(set_idx) % SETS] = (victim_way[int'(set_idx) % SETS] + 1) % WAYS;
      r.handle_valid  = 1'b1;
      r.result_handle = handle;
    end
    r.request_total   = requests_seen;
    r.hit_total       = hits_seen;
    r.collision_total = collisions_seen;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] exp_v,
                                      input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s mismatch: expected %h, got %h", name, exp_v, act_v);
      mismatches++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, time limit
  // ---------------------------------------------------------------------------
  initial begin : clock_gen
    forever #10 clk_i = ~clk_i;
  end

  // Upper bound on run time, well beyond the slowest correct run.
  initial begin : run_limit
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Result side: stall pacing and checking
  // ---------------------------------------------------------------------------
  // Stalls about 35% of cycles unless quiet; a hold-off request takes over
  // the channel for RX_HOLD_CYCLES, counted here.
  initial begin : result_pacing
    forever begin
      @(posedge clk_i);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (RX_HOLD_CYCLES) @(posedge clk_i);
      end else begin
        out_stall_i <= !rx_quiet && ($urandom_range(99) < 35);
      end
    end
  end

  // Every accepted result word is matched against the oldest expectation.
  // Values read here are the pre-edge ones, so ordering within the step
  // does not matter.
  always @(posedge clk_i) begin : result_checker
    lookup_result_t exp_r;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (lookup_results_q.size() == 0) begin
        $error("result word with no pending request");
        mismatches++;
      end else begin
        exp_r = lookup_results_q.pop_front();
        check_field("hit",             32'(exp_r.hit),          32'(hit_o));
        check_field("handle_valid",    32'(exp_r.handle_valid), 32'(handle_valid_o));
        check_field("result_handle",   exp_r.result_handle,     result_handle_o);
        check_field("evicted",         32'(exp_r.evicted),      32'(evicted_o));
        check_field("evicted_key",     exp_r.evicted_key,       evicted_key_o);
        check_field("evicted_handle",  exp_r.evicted_handle,    evicted_handle_o);
        check_field("request_total",   exp_r.request_total,     request_total_o);
        check_field("hit_total",       exp_r.hit_total,         hit_total_o);
        check_field("collision_total", exp_r.collision_total,   collision_total_o);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------
  // Offer one request word and wait for the block to take it. Valid stays
  // high on return so back-to-back words need no extra edge; a random gap
  // first lowers valid when one is drawn.
  task automatic send_word(input logic [SET_IDX_W-1:0] set_idx,
                           input logic [KEY_W-1:0]     key,
                           input logic                 ok,
                           input logic [HANDLE_W-1:0]  handle);
    int unsigned gap;
    gap = (!tx_quiet && $urandom_range(99) < 35) ? $urandom_range(3, 1) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    set_index_i  <= set_idx;
    key_i        <= key;
    build_ok_i   <= ok;
    new_handle_i <= handle;
    do @(posedge clk_i); while (in_stall_o);
    lookup_results_q.push_back(predict_lookup(set_idx, key, ok, handle));
  endtask

  // Random request: mostly hot sets and pooled keys so that hits, fills and
  // evictions on the same set follow one another closely.
  task automatic send_random_word();
    logic [SET_IDX_W-1:0] set_idx;
    logic [KEY_W-1:0]     key;
    set_idx = ($urandom_range(99) < 60) ? hot_sets[$urandom_range(3)]
                                         : SET_IDX_W'($urandom_range(SETS-1));
    key     = ($urandom_range(99) < 85) ? key_pool[$urandom_range(7)] : $urandom();
    send_word(set_idx, key, $urandom_range(99) < 85, $urandom());
  endtask

  // Drop valid, then wait until every owed result word has arrived plus a
  // short settling time.
  task automatic wait_for_results();
    int unsigned guard;
    guard = 0;
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (lookup_results_q.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (TAIL_CYCLES) @(posedge clk_i);
  endtask

  task automatic refresh_random_pools();
    foreach (key_pool[i]) key_pool[i] = $urandom();
    foreach (hot_sets[i]) hot_sets[i] = SET_IDX_W'($urandom_range(SETS-1));
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Hand-picked corner cases: hit and built miss, failed miss, filling a set
  // and wrapping the round-robin pointer, eviction reports, a failed build
  // that still hits, and extreme set, key and handle values.
  task automatic test_directed();
    send_word(6'd0,  32'h0000_0000, 1'b1, 32'h0000_0000);  // miss, stored
    send_word(6'd0,  32'h0000_0000, 1'b0, 32'hFFFF_FFFF);  // hit, handle 0
    send_word(6'd63, 32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF);  // failed miss
    send_word(6'd63, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);  // stored now
    send_word(6'd63, 32'hFFFF_FFFF, 1'b1, 32'h1234_5678);  // hit, new handle ignored
    // fill set 17, then wrap onto way 0
    send_word(6'd17, 32'hAAAA_AAAA, 1'b1, 32'h5555_5555);
    send_word(6'd17, 32'h5555_5555, 1'b1, 32'hAAAA_AAAA);
    send_word(6'd17, 32'h0000_0001, 1'b1, 32'h8000_0000);
    send_word(6'd17, 32'h8000_0000, 1'b1, 32'h0000_0001);
    send_word(6'd17, 32'hDEAD_BEEF, 1'b1, 32'hCAFE_F00D);  // evicts first key
    send_word(6'd17, 32'hAAAA_AAAA, 1'b0, 32'h0BAD_0BAD);  // gone: failed miss
    send_word(6'd17, 32'h5555_5555, 1'b0, 32'h0000_0000);  // hit despite failed build
    send_word(6'd17, 32'hAAAA_AAAA, 1'b1, 32'h1111_1111);  // evicts second key
    send_word(6'd17, 32'h5555_5555, 1'b1, 32'h2222_2222);  // refills, evicts third
    send_word(6'd0,  32'hFFFF_FFFF, 1'b1, 32'h5555_5555);
    send_word(6'd0,  32'h0000_0000, 1'b1, 32'h7777_7777);  // hit, way 0
    send_word(6'd63, 32'h0000_0000, 1'b1, 32'hFFFF_FFFF);
    send_word(6'd63, 32'h0000_0000, 1'b0, 32'h0000_0000);
    send_word(6'd42, 32'h7FFF_FFFF, 1'b0, 32'h7FFF_FFFF);  // failed miss, empty set
    send_word(6'd21, 32'hFFFF_FFFE, 1'b1, 32'hFFFF_FFFE);
    send_word(6'd21, 32'hFFFF_FFFE, 1'b1, 32'h0000_0000);
    wait_for_results();
  endtask

  // Receiver holds off while the sender keeps offering words, so the block's
  // output register and pipeline fill and the input stalls.
  task automatic test_receiver_holdoff();
    refresh_random_pools();
    tx_quiet    = 1'b1;
    rx_hold_req = 1'b1;
    repeat (16) send_random_word();
    tx_quiet = 1'b0;
    wait_for_results();
  endtask

  // Sender stops until every owed result has come back, then resumes.
  task automatic test_sender_pause();
    refresh_random_pools();
    repeat (3) begin
      repeat (10) send_random_word();
      wait_for_results();
    end
  endtask

  // Random traffic with idling on both sides.
  task automatic test_random_traffic(input int unsigned count);
    refresh_random_pools();
    for (int unsigned i = 0; i < count; i++) begin
      if (i % 200 == 199) refresh_random_pools();
      send_random_word();
    end
    wait_for_results();
  endtask

  // Full-rate stretch: neither side idles, so same-set words arrive back to
  // back and exercise the read after write on one set.
  task automatic test_streaming(input int unsigned count);
    refresh_random_pools();
    tx_quiet = 1'b1;
    rx_quiet = 1'b1;
    repeat (count) send_random_word();
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
    wait_for_results();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    // The clearing pass after reset shows up as in_stall_o; send_word waits on it.
    test_directed();
    test_receiver_holdoff();
    test_sender_pause();
    test_random_traffic(1100);
    test_streaming(500);
    test_random_traffic(100);

    if (lookup_results_q.size() != 0) begin
      $error("%0d result words never arrived", lookup_results_q.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/shc_pkg.sv
rtl/core/shc_ram.sv
rtl/core/shc_match.sv
rtl/core/set_assoc_handle_cache.sv
tb/sv/tb_set_assoc_handle_cache.sv
